// ===== src/assert_macros.svh =====
// assertion macros used by the rtl decoder top level
// each macro takes a label, clock, active-low reset, and the checked expressions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/mrpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpd_pkg
// Types and constants of the Modbus response PDU decoder: item structs,
// function codes, result kinds and status outcome codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrpd_pkg;

    // input item: one pdu byte with its last-byte flag
    typedef struct packed {
        logic [7:0] pdu_byte;
        logic       final_byte;
    } t_in_item;

    // output item: one decoded result
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] result_value;
        logic [7:0]  func_code;
        logic [2:0]  outcome;
        logic [3:0]  exception_kind;
        logic        run_end;
    } t_out_item;

    // decoder state carried from byte to byte
    typedef struct packed {
        logic [8:0]  byte_position;
        logic [7:0]  held_function;
        logic [7:0]  declared_count;
        logic [7:0]  pending_high;
        logic [15:0] echo_address;
        logic [7:0]  exception_byte;
    } t_dec_state;

    // most results one byte can cause
    localparam int unsigned MAX_RESULTS = 3;

    // position saturation point
    localparam logic [8:0] POS_MAX = 9'd511;

    // function codes
    localparam logic [7:0] FC_READ_COILS     = 8'h01;
    localparam logic [7:0] FC_READ_DISCRETE  = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
    localparam logic [7:0] FC_READ_INPUT_REG = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
    localparam logic [7:0] FC_WRITE_REG      = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS     = 8'h10;
    localparam logic [7:0] FC_EXCEPTION_BIT  = 8'h80;

    // coil on value in a single coil echo
    localparam logic [7:0] COIL_ON = 8'hFF;

    // highest known exception code
    localparam logic [3:0] EXC_CODE_MAX = 4'd11;
    localparam logic [3:0] EXC_UNKNOWN  = 4'd0;

    // result kinds
    localparam logic [2:0] KIND_COILS     = 3'd0;
    localparam logic [2:0] KIND_REG_WORD  = 3'd1;
    localparam logic [2:0] KIND_ECHO_ADDR = 3'd2;
    localparam logic [2:0] KIND_ECHO_VAL  = 3'd3;
    localparam logic [2:0] KIND_STATUS    = 3'd4;

    // status outcomes
    localparam logic [2:0] OUT_OK         = 3'd0;
    localparam logic [2:0] OUT_SHORT      = 3'd1;
    localparam logic [2:0] OUT_NO_DATA    = 3'd2;
    localparam logic [2:0] OUT_ODD_COUNT  = 3'd3;
    localparam logic [2:0] OUT_MISMATCH   = 3'd4;
    localparam logic [2:0] OUT_ECHO_SIZE  = 3'd5;
    localparam logic [2:0] OUT_UNKNOWN_FC = 3'd6;
    localparam logic [2:0] OUT_EXCEPTION  = 3'd7;

endpackage

// ===== src/modbus_response_pdu_decoder.sv =====
// ----------------------------------------------------------------------------
// modbus_response_pdu_decoder
// Decodes a Modbus response PDU given one byte per item into coil bitmaps,
// register words, echo address/value pairs and a closing status item.
// ----------------------------------------------------------------------------
// One pdu byte is taken per cycle while the output is not stalled. Each byte is
// decoded in a single pass into a result buffer of three items, which drains one
// item per cycle while i_out_ready is high; a byte that leaves at most one result
// keeps the full one-item-per-cycle rate, the last byte of a coil or register pdu
// that carries data leaves two results and holds the input until the first has
// left, and the last byte of a valid write echo leaves three results and so holds
// the input until two have left. Results appear in the cycle after their byte is
// taken. A consumer must drop the data items of a pdu whose status outcome is not ok.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modbus_response_pdu_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mrpd_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output mrpd_pkg::t_out_item   o_out_item
);

    mrpd_pkg::t_dec_state            r_state;
    mrpd_pkg::t_dec_state            n_state;
    mrpd_pkg::t_out_item [2:0]       r_items;
    mrpd_pkg::t_out_item [2:0]       n_items;
    logic [1:0]                      r_cnt;
    logic [1:0]                      n_cnt;
    logic                            in_acc;
    logic                            out_acc;

    // byte decoder
    mrpd_decode u_decode (
        .i_state (r_state),
        .i_item  (i_in_item),
        .o_state (n_state),
        .o_items (n_items),
        .o_count (n_cnt)
    );

    // handshakes: take a byte when the buffer is empty or empties this cycle
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_items[0];
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    // decoder state and result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= 2'd0;
        end else if (in_acc) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // result buffer, shifts toward slot 0 as items leave
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_items <= n_items;
        end else if (out_acc) begin
            r_items[0] <= r_items[1];
            r_items[1] <= r_items[2];
        end
    end

    // assertions
    `ASSERT_SAME(a_run_end_last, i_clk, i_rst_n, o_out_valid && o_out_item.run_end,
                 r_cnt == 2'd1, "run_end on an item that is not last in its group")
    `ASSERT_SAME(a_status_ends, i_clk, i_rst_n,
                 o_out_valid && o_out_item.result_kind == mrpd_pkg::KIND_STATUS,
                 o_out_item.run_end, "status item without run_end")
    `ASSERT_NEXT(a_final_status, i_clk, i_rst_n, in_acc && i_in_item.final_byte,
                 r_cnt != 2'd0, "last pdu byte produced no status item")
    `ASSERT_NEXT(a_final_rewind, i_clk, i_rst_n, in_acc && i_in_item.final_byte,
                 r_state.byte_position == 9'd0, "position not rewound after last byte")

endmodule

// ===== src/mrpd_decode.sv =====
// ----------------------------------------------------------------------------
// mrpd_decode
// Single-pass byte decoder: from the current state and one pdu byte it forms
// the next state and up to three result items, in delivery order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrpd_decode (
    input  mrpd_pkg::t_dec_state                 i_state,
    input  mrpd_pkg::t_in_item                   i_item,
    output mrpd_pkg::t_dec_state                 o_state,
    output mrpd_pkg::t_out_item [2:0]            o_items,
    output logic [1:0]                           o_count
);

    logic [8:0]  idx;
    logic [7:0]  b;
    logic [7:0]  fc;
    logic        live;
    logic        is_coil;
    logic        is_reg;
    logic        is_echo;
    logic [8:0]  size;
    logic [8:0]  size_less2;
    logic        has_data;
    logic        has_echo;
    logic [2:0]  outcome;
    logic [3:0]  exc_kind;
    logic [3:0]  nib;
    logic [15:0] echo_value;
    mrpd_pkg::t_dec_state nxt;
    mrpd_pkg::t_out_item  data_item;
    mrpd_pkg::t_out_item  addr_item;
    mrpd_pkg::t_out_item  val_item;
    mrpd_pkg::t_out_item  status_item;
    mrpd_pkg::t_out_item  blank_item;

    assign idx  = i_state.byte_position;
    assign b    = i_item.pdu_byte;
    assign live = (idx != mrpd_pkg::POS_MAX);

    // function code of this pdu, taken from the first byte
    assign fc   = (live && idx == 9'd0) ? b : i_state.held_function;

    // state update for this byte
    always_comb begin
        nxt = i_state;
        nxt.held_function = fc;
        if (live && idx == 9'd1) begin
            nxt.declared_count = b;
            nxt.exception_byte = b;
            nxt.echo_address   = {b, 8'h00};
        end
        if (live && idx == 9'd2) begin
            nxt.echo_address = {i_state.echo_address[15:8], b};
        end
        if (live && idx >= 9'd2 && is_reg && !idx[0]) begin
            nxt.pending_high = b;
        end
        if (live && idx == 9'd3 && is_echo) begin
            nxt.pending_high = b;
        end
        nxt.byte_position = i_item.final_byte ? 9'd0 : size;
    end

    // function code classes, on the code held for this pdu
    always_comb begin
        is_coil = fc inside {mrpd_pkg::FC_READ_COILS,
                             mrpd_pkg::FC_READ_DISCRETE};
        is_reg  = fc inside {mrpd_pkg::FC_READ_HOLDING,
                             mrpd_pkg::FC_READ_INPUT_REG};
        is_echo = fc inside {mrpd_pkg::FC_WRITE_COIL,
                             mrpd_pkg::FC_WRITE_REG,
                             mrpd_pkg::FC_WRITE_COILS,
                             mrpd_pkg::FC_WRITE_REGS};
    end

    assign size       = live ? idx + 9'd1 : mrpd_pkg::POS_MAX;
    assign size_less2 = size - 9'd2;
    assign nib        = nxt.exception_byte[3:0];

    // data result on this byte
    assign has_data = live && idx >= 9'd2 && (is_coil || (is_reg && idx[0]));

    // status outcome
    always_comb begin
        exc_kind = mrpd_pkg::EXC_UNKNOWN;
        if (size < 9'd2) begin
            outcome = mrpd_pkg::OUT_SHORT;
        end else if (nxt.held_function > mrpd_pkg::FC_EXCEPTION_BIT) begin
            outcome = mrpd_pkg::OUT_EXCEPTION;
            if (nib != 4'd0 && nib <= mrpd_pkg::EXC_CODE_MAX) begin
                exc_kind = nib;
            end
        end else if (is_coil) begin
            if (size < 9'd3) begin
                outcome = mrpd_pkg::OUT_NO_DATA;
            end else if ({1'b0, nxt.declared_count} != size_less2) begin
                outcome = mrpd_pkg::OUT_MISMATCH;
            end else begin
                outcome = mrpd_pkg::OUT_OK;
            end
        end else if (is_reg) begin
            if (size < 9'd3) begin
                outcome = mrpd_pkg::OUT_NO_DATA;
            end else if (nxt.declared_count[0]) begin
                outcome = mrpd_pkg::OUT_ODD_COUNT;
            end else if ({1'b0, nxt.declared_count} != size_less2) begin
                outcome = mrpd_pkg::OUT_MISMATCH;
            end else begin
                outcome = mrpd_pkg::OUT_OK;
            end
        end else if (is_echo) begin
            outcome = (size == 9'd5) ? mrpd_pkg::OUT_OK : mrpd_pkg::OUT_ECHO_SIZE;
        end else begin
            outcome = mrpd_pkg::OUT_UNKNOWN_FC;
        end
    end

    assign has_echo = i_item.final_byte && is_echo && size == 9'd5
                      && nxt.held_function <= mrpd_pkg::FC_EXCEPTION_BIT;

    // echoed value, single coil collapses to on/off
    assign echo_value = (nxt.held_function == mrpd_pkg::FC_WRITE_COIL)
                        ? {15'd0, nxt.pending_high == mrpd_pkg::COIL_ON}
                        : {nxt.pending_high, b};

    // result items
    always_comb begin
        blank_item                = '0;
        blank_item.func_code      = nxt.held_function;

        data_item                 = blank_item;
        data_item.result_kind     = is_coil ? mrpd_pkg::KIND_COILS : mrpd_pkg::KIND_REG_WORD;
        data_item.result_value    = is_coil ? {8'h00, b} : {i_state.pending_high, b};

        addr_item                 = blank_item;
        addr_item.result_kind     = mrpd_pkg::KIND_ECHO_ADDR;
        addr_item.result_value    = nxt.echo_address;

        val_item                  = blank_item;
        val_item.result_kind      = mrpd_pkg::KIND_ECHO_VAL;
        val_item.result_value     = echo_value;

        status_item               = blank_item;
        status_item.result_kind   = mrpd_pkg::KIND_STATUS;
        status_item.outcome       = outcome;
        status_item.exception_kind = exc_kind;
        status_item.run_end       = 1'b1;
    end

    // pack results in delivery order and mark the last one
    always_comb begin
        o_items = '0;
        if (has_echo) begin
            o_items[0] = addr_item;
            o_items[1] = val_item;
            o_items[2] = status_item;
            o_count    = 2'd3;
        end else if (has_data) begin
            o_items[0]         = data_item;
            o_items[0].run_end = !i_item.final_byte;
            o_items[1]         = status_item;
            o_count            = i_item.final_byte ? 2'd2 : 2'd1;
        end else begin
            o_items[0] = status_item;
            o_count    = i_item.final_byte ? 2'd1 : 2'd0;
        end
    end

    assign o_state = nxt;

endmodule
